FILE: hdl/tss_pkg.sv
`default_nettype none

package tss_pkg;

	localparam int SIDE_BITS = 16;
	localparam int ANGLE_FRAC_BITS = 7;

	localparam int SUM_W = SIDE_BITS + 2;
	localparam int FAC_W = SIDE_BITS + 1;
	localparam int SQ_W = 2 * SIDE_BITS;
	localparam int D_W = SQ_W + 2;
	localparam int DMAG_W = SQ_W + 1;
	localparam int M1_W = SUM_W + FAC_W;
	localparam int M2_W = 2 * FAC_W;

	// The Heron product of a valid triangle is below 3 * s^4.
	localparam int P_W = 4 * SIDE_BITS + 2;
	localparam int GUARD = 24;
	localparam int ROOT_W = (P_W + 2 * GUARD) / 2;
	localparam int REM_W = ROOT_W + 2;
	localparam int AREA_W = 33;

	localparam int NORM_BITS = 30;
	localparam int CORDIC_N = 26;
	localparam int CW = NORM_BITS + 4;
	localparam int ZF = 20;
	localparam int ZU_W = 28;
	localparam int ZW = ZU_W + 1;
	localparam int PERIM_W = 18;
	localparam int ANG_W = 15;

	localparam logic [ZU_W-1:0] Z90 = ZU_W'(90 << ZF);
	localparam logic [ZU_W-1:0] Z180 = ZU_W'(180 << ZF);
	localparam logic [ZU_W-1:0] RND_HALF = ZU_W'(1 << (ZF - ANGLE_FRAC_BITS - 1));
	localparam logic [ZU_W-1:0] ANG_LIM = ZU_W'(180 << ANGLE_FRAC_BITS);

	localparam logic [ZU_W-1:0] ATAN [CORDIC_N] = '{
		28'd47185920, 28'd27855475, 28'd14718068, 28'd7471121, 28'd3750058,
		28'd1876857, 28'd938658, 28'd469357, 28'd234682, 28'd117342,
		28'd58671, 28'd29335, 28'd14668, 28'd7334, 28'd3667, 28'd1833,
		28'd917, 28'd458, 28'd229, 28'd115, 28'd57, 28'd29, 28'd14, 28'd7,
		28'd4, 28'd2
	};

	typedef struct packed {
		logic [15:0] side_a;
		logic [15:0] side_b;
		logic [15:0] side_c;
	} tss_in_t;

	typedef struct packed {
		logic                  is_valid;
		logic [PERIM_W-1:0]    perimeter;
		logic [AREA_W-1:0]     area_quarters;
		logic [ANG_W-1:0]      angle_opp_a;
		logic [ANG_W-1:0]      angle_opp_b;
		logic [ANG_W-1:0]      angle_opp_c;
	} tss_out_t;

	typedef struct packed {
		logic                    is_valid;
		logic [PERIM_W-1:0]      perimeter;
		logic [2:0][DMAG_W-1:0]  dmag;
		logic [2:0]              dneg;
	} tss_tag_t;

	typedef struct packed {
		logic                  is_valid;
		logic [PERIM_W-1:0]    perimeter;
		logic [AREA_W-1:0]     area;
		logic [2:0]            dneg;
	} tss_ftag_t;

endpackage

`default_nettype wire

FILE: hdl/tss_prep.sv
`default_nettype none

module tss_prep (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     en,
	input  logic                     in_v,
	input  tss_pkg::tss_in_t         sides,
	output logic                     out_v,
	output logic [tss_pkg::P_W-1:0]  prod,
	output tss_pkg::tss_tag_t        tag
);

	localparam int SB = tss_pkg::SIDE_BITS;
	localparam int FAC_W = tss_pkg::FAC_W;
	localparam int SUM_W = tss_pkg::SUM_W;
	localparam int SQ_W = tss_pkg::SQ_W;
	localparam int D_W = tss_pkg::D_W;
	localparam int DMAG_W = tss_pkg::DMAG_W;
	localparam int M1_W = tss_pkg::M1_W;
	localparam int M2_W = tss_pkg::M2_W;
	localparam int P_W = tss_pkg::P_W;
	localparam int PF_W = M1_W + M2_W;

	logic [SB-1:0] a, b, c;
	logic [FAC_W-1:0] ab, bc, ac;
	logic [2:0][FAC_W-1:0] fac;
	logic [SUM_W-1:0] sum;
	logic tri_ok;

	logic v_s1, v_s2, v_s3;
	logic ok_s1, ok_s2;
	logic [SUM_W-1:0] sum_s1, sum_s2;
	logic [2:0][FAC_W-1:0] fac_s1;
	logic [2:0][SB-1:0] side_s1;
	logic [M1_W-1:0] m1_s2;
	logic [M2_W-1:0] m2_s2;
	logic [2:0][SQ_W-1:0] sq_s2;
	logic [P_W-1:0] prod_s3;
	tss_pkg::tss_tag_t tag_s3;

	logic [PF_W-1:0] pfull;
	logic [2:0][D_W-1:0] dsum;
	logic [2:0][D_W-1:0] dabs;

	always_comb begin
		a = sides.side_a[SB-1:0];
		b = sides.side_b[SB-1:0];
		c = sides.side_c[SB-1:0];
		ab = {1'b0, a} + {1'b0, b};
		bc = {1'b0, b} + {1'b0, c};
		ac = {1'b0, a} + {1'b0, c};
		fac[0] = bc - {1'b0, a};
		fac[1] = ac - {1'b0, b};
		fac[2] = ab - {1'b0, c};
		sum = {1'b0, ab} + {2'b00, c};
		tri_ok = (ab > {1'b0, c}) && (bc > {1'b0, a}) && (ac > {1'b0, b});
	end

	always_comb begin
		pfull = PF_W'(m1_s2) * PF_W'(m2_s2);
		for (int j = 0; j < 3; j++) begin
			dsum[j] = {2'b00, sq_s2[(j + 1) % 3]} + {2'b00, sq_s2[(j + 2) % 3]}
				- {2'b00, sq_s2[j]};
			dabs[j] = dsum[j][D_W-1] ? (~dsum[j] + D_W'(1)) : dsum[j];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_v;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ok_s1 <= tri_ok;
			sum_s1 <= sum;
			fac_s1 <= fac;
			side_s1 <= {c, b, a};
			ok_s2 <= ok_s1;
			sum_s2 <= sum_s1;
			m1_s2 <= M1_W'(sum_s1) * M1_W'(fac_s1[0]);
			m2_s2 <= M2_W'(fac_s1[1]) * M2_W'(fac_s1[2]);
			for (int j = 0; j < 3; j++) begin
				sq_s2[j] <= SQ_W'(side_s1[j]) * SQ_W'(side_s1[j]);
			end
			prod_s3 <= pfull[P_W-1:0];
			tag_s3.is_valid <= ok_s2;
			tag_s3.perimeter <= sum_s2;
			for (int j = 0; j < 3; j++) begin
				tag_s3.dmag[j] <= dabs[j][DMAG_W-1:0];
				tag_s3.dneg[j] <= dsum[j][D_W-1];
			end
		end
	end

	assign out_v = v_s3;
	assign prod = prod_s3;
	assign tag = tag_s3;

endmodule

`default_nettype wire

FILE: hdl/tss_sqrt.sv
`default_nettype none

module tss_sqrt (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        en,
	input  logic                        in_v,
	input  logic [tss_pkg::P_W-1:0]     prod,
	input  tss_pkg::tss_tag_t           in_tag,
	output logic                        out_v,
	output logic [tss_pkg::ROOT_W-1:0]  root,
	output tss_pkg::tss_tag_t           out_tag
);

	localparam int P_W = tss_pkg::P_W;
	localparam int ROOT_W = tss_pkg::ROOT_W;
	localparam int REM_W = tss_pkg::REM_W;
	localparam int GUARD = tss_pkg::GUARD;
	localparam int SH_W = REM_W + 2;

	logic [ROOT_W-1:0] sq_v_s;
	logic [REM_W-1:0] sq_rem_s [ROOT_W];
	logic [ROOT_W-1:0] sq_root_s [ROOT_W];
	logic [P_W-1:0] sq_prod_s [ROOT_W];
	tss_pkg::tss_tag_t sq_tag_s [ROOT_W];

	for (genvar g = 0; g < ROOT_W; g++) begin : g_st
		localparam int KK = ROOT_W - 1 - g;
		logic pv;
		logic [REM_W-1:0] prem;
		logic [ROOT_W-1:0] proot;
		logic [P_W-1:0] pprod;
		tss_pkg::tss_tag_t ptag;
		logic [1:0] pair;
		logic [SH_W-1:0] rsh, trial, diff;

		if (g == 0) begin : g_first
			assign pv = in_v;
			assign prem = '0;
			assign proot = '0;
			assign pprod = prod;
			assign ptag = in_tag;
		end else begin : g_next
			assign pv = sq_v_s[g-1];
			assign prem = sq_rem_s[g-1];
			assign proot = sq_root_s[g-1];
			assign pprod = sq_prod_s[g-1];
			assign ptag = sq_tag_s[g-1];
		end

		if (KK >= GUARD) begin : g_pair
			assign pair = pprod[2*(KK-GUARD)+1 -: 2];
		end else begin : g_zero
			assign pair = 2'b00;
		end

		assign rsh = {prem, pair};
		assign trial = {2'b00, proot, 2'b01};
		assign diff = rsh - trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				sq_v_s[g] <= 1'b0;
			end else if (en) begin
				sq_v_s[g] <= pv;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				if (rsh >= trial) begin
					sq_rem_s[g] <= diff[REM_W-1:0];
					sq_root_s[g] <= {proot[ROOT_W-2:0], 1'b1};
				end else begin
					sq_rem_s[g] <= rsh[REM_W-1:0];
					sq_root_s[g] <= {proot[ROOT_W-2:0], 1'b0};
				end
				sq_prod_s[g] <= pprod;
				sq_tag_s[g] <= ptag;
			end
		end
	end

	assign out_v = sq_v_s[ROOT_W-1];
	assign root = sq_root_s[ROOT_W-1];
	assign out_tag = sq_tag_s[ROOT_W-1];

endmodule

`default_nettype wire

FILE: hdl/tss_norm.sv
`default_nettype none

module tss_norm (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  en,
	input  logic                                  in_v,
	input  logic [tss_pkg::ROOT_W-1:0]            root,
	input  tss_pkg::tss_tag_t                     in_tag,
	output logic                                  out_v,
	output logic [2:0][tss_pkg::NORM_BITS-1:0]    x,
	output logic [2:0][tss_pkg::NORM_BITS-1:0]    y,
	output tss_pkg::tss_ftag_t                    out_tag
);

	localparam int XW = tss_pkg::ROOT_W;
	localparam int NB = tss_pkg::NORM_BITS;
	localparam int GUARD = tss_pkg::GUARD;

	typedef struct packed {
		logic [XW-1:0] x;
		logic [XW-1:0] y;
	} nxy_t;

	function automatic nxy_t nstep(input nxy_t v, input int k, input int thr);
		nxy_t r;
		logic [XW-1:0] t;
		t = (v.x | v.y) >> NB;
		r = v;
		if ((t >> thr) != '0) begin
			r.x = v.x >> k;
			r.y = v.y >> k;
		end
		return r;
	endfunction

	logic v_s1, v_s2, v_s3;
	nxy_t [2:0] xy_s1, xy_s2, xy_s3;
	tss_pkg::tss_ftag_t ft_s1, ft_s2, ft_s3;
	nxy_t [2:0] xy_in;

	always_comb begin
		for (int j = 0; j < 3; j++) begin
			xy_in[j].x = {in_tag.dmag[j], {GUARD{1'b0}}};
			xy_in[j].y = root;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_v;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int j = 0; j < 3; j++) begin
				xy_s1[j] <= nstep(nstep(xy_in[j], 16, 16), 8, 8);
				xy_s2[j] <= nstep(nstep(xy_s1[j], 4, 4), 2, 2);
				xy_s3[j] <= nstep(nstep(xy_s2[j], 1, 1), 1, 0);
			end
			ft_s1.is_valid <= in_tag.is_valid;
			ft_s1.perimeter <= in_tag.perimeter;
			ft_s1.area <= root[XW-1:GUARD];
			ft_s1.dneg <= in_tag.dneg;
			ft_s2 <= ft_s1;
			ft_s3 <= ft_s2;
		end
	end

	always_comb begin
		for (int j = 0; j < 3; j++) begin
			x[j] = xy_s3[j].x[NB-1:0];
			y[j] = xy_s3[j].y[NB-1:0];
		end
	end

	assign out_v = v_s3;
	assign out_tag = ft_s3;

endmodule

`default_nettype wire

FILE: hdl/tss_cordic.sv
`default_nettype none

module tss_cordic (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   en,
	input  logic                                   in_v,
	input  logic [2:0][tss_pkg::NORM_BITS-1:0]     x,
	input  logic [2:0][tss_pkg::NORM_BITS-1:0]     y,
	input  tss_pkg::tss_ftag_t                     in_tag,
	output logic                                   out_v,
	output logic [2:0][tss_pkg::ZW-1:0]            z,
	output tss_pkg::tss_ftag_t                     out_tag
);

	localparam int N = tss_pkg::CORDIC_N;
	localparam int CW = tss_pkg::CW;
	localparam int ZW = tss_pkg::ZW;
	localparam int NB = tss_pkg::NORM_BITS;

	logic [N-1:0] cr_v_s;
	logic signed [CW-1:0] cr_x_s [N][3];
	logic signed [CW-1:0] cr_y_s [N][3];
	logic signed [ZW-1:0] cr_z_s [N][3];
	tss_pkg::tss_ftag_t cr_tag_s [N];

	for (genvar i = 0; i < N; i++) begin : g_st
		logic pv;
		tss_pkg::tss_ftag_t ptag;

		if (i == 0) begin : g_first
			assign pv = in_v;
			assign ptag = in_tag;
		end else begin : g_next
			assign pv = cr_v_s[i-1];
			assign ptag = cr_tag_s[i-1];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				cr_v_s[i] <= 1'b0;
			end else if (en) begin
				cr_v_s[i] <= pv;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				cr_tag_s[i] <= ptag;
			end
		end

		for (genvar j = 0; j < 3; j++) begin : g_ln
			logic signed [CW-1:0] xi, yi;
			logic signed [ZW-1:0] zi, ai;

			if (i == 0) begin : g_first
				assign xi = $signed({{(CW - NB){1'b0}}, x[j]});
				assign yi = $signed({{(CW - NB){1'b0}}, y[j]});
				assign zi = '0;
			end else begin : g_next
				assign xi = cr_x_s[i-1][j];
				assign yi = cr_y_s[i-1][j];
				assign zi = cr_z_s[i-1][j];
			end

			assign ai = $signed(ZW'(tss_pkg::ATAN[i]));

			always_ff @(posedge clk) begin
				if (en) begin
					if (yi >= 0) begin
						cr_x_s[i][j] <= xi + (yi >>> i);
						cr_y_s[i][j] <= yi - (xi >>> i);
						cr_z_s[i][j] <= zi + ai;
					end else begin
						cr_x_s[i][j] <= xi - (yi >>> i);
						cr_y_s[i][j] <= yi + (xi >>> i);
						cr_z_s[i][j] <= zi - ai;
					end
				end
			end
		end
	end

	always_comb begin
		for (int j = 0; j < 3; j++) begin
			z[j] = cr_z_s[N-1][j];
		end
	end

	assign out_v = cr_v_s[N-1];
	assign out_tag = cr_tag_s[N-1];

endmodule

`default_nettype wire

FILE: hdl/triangle_side_solver.sv
// Triangle side solver.
// The sides channel (sides_valid, sides_stall, sides) carries one triangle per
// transaction; the result channel (result_valid, result_stall, result) returns
// one result per triangle, in order: validity, perimeter, four times the area
// and the three angles in degrees with seven fraction bits.
// A transaction completes on a rising edge where valid is high and stall is low.
// Throughput is one triangle per cycle while sides_stall is low. From input to
// result a triangle passes the registers of sums, products and squares, the
// square root stages (one result bit per stage), three normalizing stages, 26
// CORDIC stages and the output register.
// Invalid triangles give zero area and zero angles; the perimeter is still given.
// When the receiver stalls, the result register holds and one more result is
// caught in a skid register; sides_stall then rises and the whole pipeline
// freezes until the skid register drains. Nothing is dropped or repeated.
// Reset empties the pipeline and the output; no result appears until a new
// triangle has been accepted.
`default_nettype none

module triangle_side_solver (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               sides_valid,
	output logic               sides_stall,
	input  tss_pkg::tss_in_t   sides,
	output logic               result_valid,
	input  logic               result_stall,
	output tss_pkg::tss_out_t  result
);

	localparam int P_W = tss_pkg::P_W;
	localparam int ROOT_W = tss_pkg::ROOT_W;
	localparam int NB = tss_pkg::NORM_BITS;
	localparam int ZW = tss_pkg::ZW;
	localparam int ZU_W = tss_pkg::ZU_W;
	localparam int SH = tss_pkg::ZF - tss_pkg::ANGLE_FRAC_BITS;
	localparam int ANG_W = tss_pkg::ANG_W;

	logic en;
	logic pr_v, sq_v, nm_v, cr_v;
	logic [P_W-1:0] pr_prod;
	tss_pkg::tss_tag_t pr_tag, sq_tag;
	logic [ROOT_W-1:0] sq_root;
	logic [2:0][NB-1:0] nm_x, nm_y;
	tss_pkg::tss_ftag_t nm_tag, cr_tag;
	logic [2:0][ZW-1:0] cr_z;

	logic [2:0][ZU_W-1:0] zc, tot, rnd, ang;
	tss_pkg::tss_out_t fin;

	logic out_v_q, skid_v_q;
	tss_pkg::tss_out_t out_q, skid_q;

	assign en = !skid_v_q;
	assign sides_stall = skid_v_q;

	tss_prep u_prep (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.in_v   (sides_valid),
		.sides  (sides),
		.out_v  (pr_v),
		.prod   (pr_prod),
		.tag    (pr_tag)
	);

	tss_sqrt u_sqrt (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_v    (pr_v),
		.prod    (pr_prod),
		.in_tag  (pr_tag),
		.out_v   (sq_v),
		.root    (sq_root),
		.out_tag (sq_tag)
	);

	tss_norm u_norm (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_v    (sq_v),
		.root    (sq_root),
		.in_tag  (sq_tag),
		.out_v   (nm_v),
		.x       (nm_x),
		.y       (nm_y),
		.out_tag (nm_tag)
	);

	tss_cordic u_cordic (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_v    (nm_v),
		.x       (nm_x),
		.y       (nm_y),
		.in_tag  (nm_tag),
		.out_v   (cr_v),
		.z       (cr_z),
		.out_tag (cr_tag)
	);

	always_comb begin
		for (int j = 0; j < 3; j++) begin
			if (cr_z[j][ZW-1]) begin
				zc[j] = '0;
			end else if (cr_z[j][ZU_W-1:0] > tss_pkg::Z90) begin
				zc[j] = tss_pkg::Z90;
			end else begin
				zc[j] = cr_z[j][ZU_W-1:0];
			end
			tot[j] = cr_tag.dneg[j] ? (tss_pkg::Z180 - zc[j]) : zc[j];
			rnd[j] = (tot[j] + tss_pkg::RND_HALF) >> SH;
			ang[j] = (rnd[j] > tss_pkg::ANG_LIM) ? tss_pkg::ANG_LIM : rnd[j];
			if (!cr_tag.is_valid) begin
				ang[j] = '0;
			end
		end
		fin.is_valid = cr_tag.is_valid;
		fin.perimeter = cr_tag.perimeter;
		fin.area_quarters = cr_tag.is_valid ? cr_tag.area : '0;
		fin.angle_opp_a = ang[0][ANG_W-1:0];
		fin.angle_opp_b = ang[1][ANG_W-1:0];
		fin.angle_opp_c = ang[2][ANG_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (!out_v_q || !result_stall) begin
			if (skid_v_q) begin
				out_v_q <= 1'b1;
				skid_v_q <= 1'b0;
			end else begin
				out_v_q <= cr_v;
			end
		end else if (cr_v && !skid_v_q) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_v_q || !result_stall) begin
			out_q <= skid_v_q ? skid_q : fin;
		end else if (!skid_v_q) begin
			skid_q <= fin;
		end
	end

	assign result_valid = out_v_q;
	assign result = out_q;

`ifndef NO_ASSERTIONS
	a_skid_needs_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q |-> out_v_q)
		else $error("Skid register holds a transaction while the output is empty.");

	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && !result.is_valid) |-> (result.area_quarters == '0
		&& result.angle_opp_a == '0 && result.angle_opp_b == '0
		&& result.angle_opp_c == '0))
		else $error("Invalid triangle produced a nonzero area or angle.");

	a_angle_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (ZU_W'(result.angle_opp_a) <= tss_pkg::ANG_LIM
		&& ZU_W'(result.angle_opp_b) <= tss_pkg::ANG_LIM
		&& ZU_W'(result.angle_opp_c) <= tss_pkg::ANG_LIM))
		else $error("Angle exceeds 180 degrees.");

	a_skid_drains: assert property (@(posedge clk) disable iff (!arst_n)
		(skid_v_q && !result_stall) |=> (!skid_v_q && out_v_q))
		else $error("Skid register failed to drain into the output.");
`endif

endmodule

`default_nettype wire
